FILE: rtl/core/lars_pkg.sv
// Package for the raster Life step block: payload types, limits and the cell rule.
`timescale 1ns / 1ps
`default_nettype none

package lars_pkg;

  // Default limits of the row stores and the row counter
  localparam int MAX_ROW_LENGTH = 256;
  localparam int MAX_ROWS       = 4095;

  // Configuration register widths, indexes and reset values
  localparam int GRID_WIDTH_W   = 9;
  localparam int GRID_HEIGHT_W  = 12;
  localparam int CFG_DATA_W     = 32;
  localparam int CFG_ADDR_W     = 3;
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;
  localparam logic [GRID_WIDTH_W-1:0]  GRID_WIDTH_RST  = 9'd256;
  localparam logic [GRID_HEIGHT_W-1:0] GRID_HEIGHT_RST = 12'd256;

  // Neighbor counts of the B3/S23 rule
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  // Window column width and the bit of the center cell
  localparam int WIN_COL_W  = 3;
  localparam int WIN_W      = 9;
  localparam int WIN_CENTER = 4;

  typedef struct packed {
    logic operation;
    logic cell_alive;
  } in_item_t;

  typedef struct packed {
    logic       next_alive;
    logic [3:0] neighbor_count;
    logic       row_end;
    logic       frame_end;
    logic       last_of_item;
  } out_item_t;

  // Build one result from a 3x3 window (column k in bits 3k..3k+2, top row lowest)
  function automatic out_item_t make_result(input logic [WIN_W-1:0] win,
                                            input logic row_end,
                                            input logic frame_end,
                                            input logic last_of_item);
    out_item_t  res;
    logic [3:0] cnt;
    cnt = 4'd0;
    for (int b = 0; b < WIN_W; b++) begin
      if (b != WIN_CENTER) begin
        cnt = cnt + {3'd0, win[b]};
      end
    end
    res.neighbor_count = cnt;
    if (cnt == BIRTH_COUNT) begin
      res.next_alive = 1'b1;
    end else if (cnt == SURVIVE_COUNT) begin
      res.next_alive = win[WIN_CENTER];
    end else begin
      res.next_alive = 1'b0;
    end
    res.row_end      = row_end;
    res.frame_end    = frame_end;
    res.last_of_item = last_of_item;
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/life_automaton_raster_step.sv
// Result path: an item's first result reaches out_data once the item has passed the
// work stage registers and been written into the output queue.
// Throughput: one item per cycle while the output queue has room for the work stage's
// results; an item at the end of a row gives two results, which the two-entry output
// queue delivers in turn while the next row's first item gives none.
// Reset (synchronous, rst_n low): counters, window and queue clear, registers take
// 256/256, then a clearing pass over all MAX_ROW_LENGTH entries zeroes the row stores
// while in_stall stays high; configuration writes are taken during the pass.
`timescale 1ns / 1ps
`default_nettype none

module life_automaton_raster_step #(
  parameter int MAX_ROW_LENGTH = lars_pkg::MAX_ROW_LENGTH,
  parameter int MAX_ROWS       = lars_pkg::MAX_ROWS
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // input channel
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  lars_pkg::in_item_t                  in_data,
  // result channel
  output logic                                out_valid,
  input  wire                                 out_stall,
  output lars_pkg::out_item_t                 out_data,
  // configuration port
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire [lars_pkg::CFG_ADDR_W-1:0]      paddr,
  input  wire [lars_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [lars_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int CW = $clog2(MAX_ROW_LENGTH);
  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int GW = lars_pkg::GRID_WIDTH_W;
  localparam int HW = lars_pkg::GRID_HEIGHT_W;
  localparam int NW = lars_pkg::WIN_W;
  localparam int KW = lars_pkg::WIN_COL_W;
  localparam int DW = lars_pkg::CFG_DATA_W;

  // Configuration registers
  logic [GW-1:0] grid_width_r;
  logic [HW-1:0] grid_height_r;
  logic          cfg_wr;
  logic          cfg_idx;

  // Position counters and clamped views
  logic [CW-1:0] col_pos_r, col_pos_nxt;
  logic [RW-1:0] row_pos_r, row_pos_nxt;
  logic [CW-1:0] last_col;
  logic [RW-1:0] h_eff;
  logic [CW-1:0] c_cur;
  logic [RW-1:0] r_cur;
  logic          pad_cur;
  logic          clast_cur;
  logic          cell_cur;
  logic          in_accept;

  // Row store memory: bit 1 = middle row, bit 0 = upper row
  logic [1:0]    row_mem [MAX_ROW_LENGTH];
  logic [1:0]    rd_r;
  logic          mem_we;
  logic [CW-1:0] mem_waddr;
  logic [1:0]    mem_wdata;
  logic          clear_r;
  logic [CW-1:0] clear_addr_r;

  // Work stage
  logic          s1_valid_r;
  logic          s1_cell_r;
  logic [CW-1:0] s1_col_r;
  logic          s1_rzero_r;
  logic          s1_cfirst_r;
  logic          s1_clast_r;
  logic          s1_pad_r;
  logic          s1_fire;
  logic [NW-1:0] win_r, win_nxt;
  logic [NW-1:0] win_cur, win_sh;
  logic [KW-1:0] col_bits;
  logic          emit0, emit1;
  logic [1:0]    push_n;
  lars_pkg::out_item_t res0, res1;

  // Output queue
  lars_pkg::out_item_t out_buf_r [2];
  logic          wptr_r, rptr_r;
  logic [1:0]    count_r;
  logic          pop;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= lars_pkg::GRID_WIDTH_RST;
      grid_height_r <= lars_pkg::GRID_HEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        lars_pkg::REG_GRID_WIDTH:  grid_width_r  <= pwdata[GW-1:0];
        lars_pkg::REG_GRID_HEIGHT: grid_height_r <= pwdata[HW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      lars_pkg::REG_GRID_WIDTH:  prdata = DW'(grid_width_r);
      lars_pkg::REG_GRID_HEIGHT: prdata = DW'(grid_height_r);
      default:                   prdata = '0;
    endcase
  end

  // Clamp the grid size to the supported range
  always_comb begin
    if (grid_width_r < GW'(2)) begin
      last_col = CW'(1);
    end else if (32'(grid_width_r) > 32'(MAX_ROW_LENGTH)) begin
      last_col = CW'(MAX_ROW_LENGTH - 1);
    end else begin
      last_col = CW'(grid_width_r - GW'(1));
    end
    if (grid_height_r == '0) begin
      h_eff = RW'(1);
    end else if (32'(grid_height_r) > 32'(MAX_ROWS)) begin
      h_eff = RW'(MAX_ROWS);
    end else begin
      h_eff = RW'(grid_height_r);
    end
  end

  // Position of the incoming item; padding row and dead markers read as dead
  always_comb begin
    c_cur     = (col_pos_r > last_col) ? last_col : col_pos_r;
    pad_cur   = (row_pos_r >= h_eff);
    r_cur     = pad_cur ? h_eff : row_pos_r;
    clast_cur = (c_cur == last_col);
    cell_cur  = (pad_cur || in_data.operation) ? 1'b0 : in_data.cell_alive;
    if (clast_cur) begin
      col_pos_nxt = '0;
      row_pos_nxt = pad_cur ? '0 : r_cur + RW'(1);
    end else begin
      col_pos_nxt = c_cur + CW'(1);
      row_pos_nxt = row_pos_r;
    end
  end

  assign in_stall  = clear_r || (s1_valid_r && !s1_fire);
  assign in_accept = in_valid && !in_stall;

  // Advance the raster position on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r <= '0;
      row_pos_r <= '0;
    end else if (in_accept) begin
      col_pos_r <= col_pos_nxt;
      row_pos_r <= row_pos_nxt;
    end
  end

  // Sweep the row stores to dead after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_r      <= 1'b1;
      clear_addr_r <= '0;
    end else if (clear_r) begin
      clear_addr_r <= clear_addr_r + CW'(1);
      if (clear_addr_r == CW'(MAX_ROW_LENGTH - 1)) begin
        clear_r <= 1'b0;
      end
    end
  end

  // Row store write port: clearing pass or the item leaving the work stage
  always_comb begin
    if (clear_r) begin
      mem_we    = 1'b1;
      mem_waddr = clear_addr_r;
      mem_wdata = 2'b00;
    end else begin
      mem_we    = s1_fire;
      mem_waddr = s1_col_r;
      mem_wdata = {s1_cell_r, s1_rzero_r ? 1'b0 : rd_r[1]};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      row_mem[mem_waddr] <= mem_wdata;
    end
    if (in_accept) begin
      rd_r <= row_mem[c_cur];
    end
  end

  // Work stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Hold the item's cell and position flags for the work stage
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cell_r   <= cell_cur;
      s1_col_r    <= c_cur;
      s1_rzero_r  <= (r_cur == '0);
      s1_cfirst_r <= (c_cur == '0);
      s1_clast_r  <= clast_cur;
      s1_pad_r    <= pad_cur;
    end
  end

  // Slide the window and form up to two results; a result popped this cycle frees room
  always_comb begin
    col_bits = {s1_cell_r, rd_r[1], rd_r[0]};
    if (s1_cfirst_r) begin
      win_cur = {col_bits, {(NW - KW){1'b0}}};
    end else begin
      win_cur = {col_bits, win_r[NW-1:KW]};
    end
    win_sh  = {{KW{1'b0}}, win_cur[NW-1:KW]};
    emit0   = !s1_rzero_r && !s1_cfirst_r;
    emit1   = !s1_rzero_r && s1_clast_r;
    win_nxt = emit1 ? win_sh : win_cur;
    res0    = lars_pkg::make_result(win_cur, 1'b0, 1'b0, !emit1);
    res1    = lars_pkg::make_result(win_sh, 1'b1, s1_pad_r, 1'b1);
    if (emit0 && emit1) begin
      push_n = 2'd2;
    end else if (emit0) begin
      push_n = 2'd1;
    end else begin
      push_n = 2'd0;
    end
    s1_fire = s1_valid_r &&
              ((push_n == 2'd0) ||
               ((push_n == 2'd1) && ((count_r != 2'd2) || pop)) ||
               ((push_n == 2'd2) && ((count_r == 2'd0) || ((count_r == 2'd1) && pop))));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_fire) begin
      win_r <= win_nxt;
    end
  end

  // Output queue: two entries, one result popped per cycle while out_stall is low
  assign out_valid = (count_r != 2'd0);
  assign out_data  = out_buf_r[rptr_r];
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (s1_fire) begin
        wptr_r <= wptr_r ^ push_n[0];
      end
      if (pop) begin
        rptr_r <= !rptr_r;
      end
      count_r <= count_r + (s1_fire ? push_n : 2'd0) - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && (push_n != 2'd0)) begin
      out_buf_r[wptr_r] <= res0;
      if (push_n == 2'd2) begin
        out_buf_r[!wptr_r] <= res1;
      end
    end
  end

endmodule

`default_nettype wire
